### hw/rtl/tcs_pkg.sv
package tcs_pkg;

  // Operation codes carried in each input word
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_SERVICE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICKS_PER_TICK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNTDOWN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_COUNTDOWN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_ENABLE      = 2'd3;

  // Register reset values
  localparam logic [31:0] RST_CLICKS_PER_TICK  = 32'd10000;
  localparam logic [15:0] RST_START_COUNTDOWN  = 16'd10;
  localparam logic [15:0] RST_RELOAD_COUNTDOWN = 16'd1;
  localparam logic        RST_TICK_ENABLE      = 1'b1;

  // Lead window on compare advance
  localparam logic [31:0] LEAD_MIN   = 32'd400;
  localparam logic [31:0] LEAD_FUDGE = 32'd1000;

  typedef struct packed {
    logic [31:0] clicks_per_tick;
    logic [15:0] start_countdown;
    logic [15:0] reload_countdown;
    logic        tick_enable;
  } cfg_t;

  typedef struct packed {
    logic [63:0] extended_count;
    logic [31:0] compare_value;
    logic        compare_write;
    logic        os_tick;
    logic        lead_recovered;
    logic [31:0] interrupt_count;
  } res_t;

endpackage

### hw/rtl/tcs_in_if.sv
interface tcs_in_if import tcs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] timer_sample;

  modport source (output valid, output op, output timer_sample, input ready);
  modport sink   (input valid, input op, input timer_sample, output ready);
endinterface

### hw/rtl/tcs_out_if.sv
interface tcs_out_if import tcs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] extended_count;
  logic [31:0] compare_value;
  logic        compare_write;
  logic        os_tick;
  logic        lead_recovered;
  logic [31:0] interrupt_count;

  modport source (output valid, output extended_count, output compare_value,
                  output compare_write, output os_tick, output lead_recovered,
                  output interrupt_count, input ready);
  modport sink   (input valid, input extended_count, input compare_value,
                  input compare_write, input os_tick, input lead_recovered,
                  input interrupt_count, output ready);
endinterface

### hw/rtl/tcs_cfg_regs.sv
module tcs_cfg_regs import tcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clicks_per_tick  <= RST_CLICKS_PER_TICK;
      cfg_r.start_countdown  <= RST_START_COUNTDOWN;
      cfg_r.reload_countdown <= RST_RELOAD_COUNTDOWN;
      cfg_r.tick_enable      <= RST_TICK_ENABLE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLICKS_PER_TICK:  cfg_r.clicks_per_tick  <= cfg_wdata[31:0];
        CFG_START_COUNTDOWN:  cfg_r.start_countdown  <= cfg_wdata[15:0];
        CFG_RELOAD_COUNTDOWN: cfg_r.reload_countdown <= cfg_wdata[15:0];
        CFG_TICK_ENABLE:      cfg_r.tick_enable      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/tcs_engine.sv
module tcs_engine import tcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [1:0]  op,
  input  logic [31:0] sample,
  input  cfg_t        cfg,
  output res_t        res
);

  logic [63:0] clicks_r, clicks_nxt;
  logic [31:0] compare_r, compare_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [31:0] serviced_r, serviced_nxt;

  logic [31:0] ext_hi;
  logic [63:0] ext_count;
  logic [31:0] cmp_adv;
  logic [31:0] lead;
  logic        lead_bad;
  logic        wrote;
  logic        tick;
  logic        recovered;

  // Wrap extension: a sample below the low half means the timer wrapped
  assign ext_hi    = (sample < clicks_r[31:0]) ? clicks_r[63:32] + 32'd1 : clicks_r[63:32];
  assign ext_count = {ext_hi, sample};
  assign cmp_adv   = compare_r + cfg.clicks_per_tick;
  assign lead      = cmp_adv - sample;
  assign lead_bad  = (lead < LEAD_MIN) || (lead > cfg.clicks_per_tick);

  always_comb begin
    clicks_nxt    = clicks_r;
    compare_nxt   = compare_r;
    countdown_nxt = countdown_r;
    serviced_nxt  = serviced_r;
    wrote         = 1'b0;
    tick          = 1'b0;
    recovered     = 1'b0;
    case (op)
      OP_READ: begin
        clicks_nxt = ext_count;
      end
      OP_START: begin
        serviced_nxt  = '0;
        countdown_nxt = cfg.start_countdown;
        if (cfg.tick_enable) begin
          // Counters clear first, so extend from zero
          clicks_nxt  = {32'd0, sample};
          compare_nxt = sample + cfg.clicks_per_tick;
          wrote       = 1'b1;
        end else begin
          clicks_nxt  = '0;
          compare_nxt = '0;
        end
      end
      OP_SERVICE: begin
        clicks_nxt   = ext_count;
        wrote        = 1'b1;
        serviced_nxt = serviced_r + 32'd1;
        if (lead_bad) begin
          compare_nxt = sample + LEAD_FUDGE;
          recovered   = 1'b1;
        end else begin
          compare_nxt = cmp_adv;
        end
        if (countdown_r == 16'd1) begin
          tick          = 1'b1;
          countdown_nxt = (cfg.reload_countdown == 16'd0) ? 16'd1 : cfg.reload_countdown;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clicks_r    <= '0;
      compare_r   <= '0;
      countdown_r <= '0;
      serviced_r  <= '0;
    end else if (fire) begin
      clicks_r    <= clicks_nxt;
      compare_r   <= compare_nxt;
      countdown_r <= countdown_nxt;
      serviced_r  <= serviced_nxt;
    end
  end

  assign res.extended_count  = clicks_nxt;
  assign res.compare_value   = compare_nxt;
  assign res.compare_write   = wrote;
  assign res.os_tick         = tick;
  assign res.lead_recovered  = recovered;
  assign res.interrupt_count = serviced_nxt;

  a_service_counts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == OP_SERVICE |=> serviced_r == $past(serviced_r) + 32'd1)
    else $error("serviced count did not advance on service");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == OP_START |=> serviced_r == 32'd0 && countdown_r == $past(cfg.start_countdown))
    else $error("start did not clear counters");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(compare_r) && $stable(clicks_r) && $stable(countdown_r))
    else $error("state moved without a word");

  a_tick_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (res.os_tick || res.lead_recovered) |-> res.compare_write && op == OP_SERVICE)
    else $error("tick or recovery flagged outside service");

endmodule

### hw/rtl/tick_compare_scheduler.sv
// Channel   Dir  Payload                                               Handshake
// in_bus    in   op, timer_sample                                      valid/ready
// out_bus   out  extended_count, compare_value, compare_write,         valid/ready
//                os_tick, lead_recovered, interrupt_count
// cfg_*     in   cfg_index, cfg_wdata                                  cfg_we, no wait
//
// One word per cycle sustained while out_bus is not stalled; a word taken passes through the
// input register, then the result register, where its result is presented to out_bus.
// The compare, lead check and wrap extension all settle in the single pass between them.
// Reset (rst_n low, synchronous) empties both registers, zeroes the counters and
// restores the configuration defaults.
// With out_bus stalled the result register holds and one more word is taken into the
// input register; in_bus ready then drops until the result is taken.
module tick_compare_scheduler import tcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcs_in_if.sink                in_bus,
  tcs_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg;
  res_t        res;

  logic        in_valid_r, in_valid_nxt;
  logic [1:0]  in_op_r;
  logic [31:0] in_sample_r;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;

  logic        advance;
  logic        take_in;

  tcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held word when the result register is free or being drained
  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;
  assign take_in      = in_bus.valid && in_bus.ready;

  tcs_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .op     (in_op_r),
    .sample (in_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  assign in_valid_nxt  = take_in || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_op_r     <= in_bus.op;
      in_sample_r <= in_bus.timer_sample;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.extended_count  = out_res_r.extended_count;
  assign out_bus.compare_value   = out_res_r.compare_value;
  assign out_bus.compare_write   = out_res_r.compare_write;
  assign out_bus.os_tick         = out_res_r.os_tick;
  assign out_bus.lead_recovered  = out_res_r.lead_recovered;
  assign out_bus.interrupt_count = out_res_r.interrupt_count;

endmodule
